>>> rtl/sfir_pkg.sv
// Shared constants, control structs and coefficient table of the symmetric FIR filter.
package sfir_pkg;

   localparam int TAP_COUNT_DEF    = 47;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_W           = 16;
   localparam int COEF_FRAC        = 15;

   typedef struct packed {
      logic load;
      logic shift;
   } sfir_cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic feed;
   } sfir_mac_ctrl_type;

   function automatic logic signed [COEF_W-1:0] coef_at(input logic [7:0] k);
      logic signed [COEF_W-1:0] c;
      case (k)
         8'd0:    c = -16'sd768;
         8'd1:    c = 16'sd84;
         8'd2:    c = 16'sd102;
         8'd3:    c = 16'sd132;
         8'd4:    c = 16'sd175;
         8'd5:    c = 16'sd229;
         8'd6:    c = 16'sd293;
         8'd7:    c = 16'sd366;
         8'd8:    c = 16'sd447;
         8'd9:    c = 16'sd535;
         8'd10:   c = 16'sd628;
         8'd11:   c = 16'sd724;
         8'd12:   c = 16'sd822;
         8'd13:   c = 16'sd918;
         8'd14:   c = 16'sd1014;
         8'd15:   c = 16'sd1106;
         8'd16:   c = 16'sd1192;
         8'd17:   c = 16'sd1270;
         8'd18:   c = 16'sd1340;
         8'd19:   c = 16'sd1399;
         8'd20:   c = 16'sd1446;
         8'd21:   c = 16'sd1480;
         8'd22:   c = 16'sd1501;
         8'd23:   c = 16'sd1508;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/sfir_if.sv
// Valid/ready stream interfaces for the sample and result channels.
interface sfir_req_if #(parameter int WIDTH = 16) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface sfir_rsp_if #(parameter int WIDTH = 16) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/symmetric_fir_filter_47tap_core.sv
// Symmetric linear-phase FIR filter: delay line, pre-add cell chain and shared MAC.
//
// Input channel req: one signed Q1.15 sample per transaction (sample_in).
// Output channel rsp: one filtered, rounded and saturated sample per
// transaction (sample_out), in input order.
// On acceptance the sample enters the delay line and each pre-add cell
// loads the sum of its mirrored pair. The cells then shift their sums
// toward a single multiply-accumulate unit, one per cycle, so the chain
// length (TAP_COUNT+1)/2 cells sets the work time.
// From acceptance the controller steps through the FEED, DRAIN and EMIT
// states, and the result enters the output register as EMIT completes. No
// new sample is taken until the block has returned to idle.
// req.ready is high while the block is idle, also while a result still
// waits in the output register.
// When the receiver stalls, the result holds in the output register; a
// following result that finishes meanwhile waits in the MAC until it drains.
// Reset (synchronous, active high) clears the delay line to zeros, drops
// any pending result and returns the block to idle.
module symmetric_fir_filter_47tap_core #(
   parameter int TAP_COUNT    = sfir_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sfir_req_if.sink    req,
   sfir_rsp_if.source  rsp
);
   import sfir_pkg::*;

   localparam int DEPTH      = TAP_COUNT - 1;
   localparam int CELL_COUNT = (TAP_COUNT + 1) / 2;
   localparam int PAIR_W     = SAMPLE_WIDTH + 1;
   localparam int CNT_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FEED  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic signed [SAMPLE_WIDTH-1:0]  delay_ff [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0]  delay_in [DEPTH];
   logic signed [PAIR_W-1:0]        pair [CELL_COUNT];
   logic                            out_valid_ff, out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]  out_data_ff, out_data_in;
   logic signed [SAMPLE_WIDTH-1:0]  mac_result;
   logic                            accept;
   logic                            emit_fire;
   sfir_cell_ctrl_type              cell_ctrl;
   sfir_mac_ctrl_type               mac_ctrl;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign emit_fire = (state_ff == ST_EMIT) && (!out_valid_ff || rsp.ready);

   assign cell_ctrl.load  = accept;
   assign cell_ctrl.shift = (state_ff == ST_FEED);
   assign mac_ctrl.clear  = accept;
   assign mac_ctrl.feed   = (state_ff == ST_FEED);

   // advance the delay line on each accepted sample
   always_comb begin
      delay_in = delay_ff;
      if (accept) begin
         delay_in[0] = req.sample_in;
         for (int i = 1; i < DEPTH; i++) begin
            delay_in[i] = delay_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         delay_ff <= delay_in;
      end
   end

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      localparam int OLD_AGE = TAP_COUNT - 1 - k;
      logic signed [SAMPLE_WIDTH-1:0] newer;
      logic signed [SAMPLE_WIDTH-1:0] older;
      logic signed [PAIR_W-1:0]       next_pair;

      if (k == 0) begin : g_head
         assign newer = req.sample_in;
      end else begin : g_line
         assign newer = delay_ff[k-1];
      end

      if (OLD_AGE == k) begin : g_middle
         assign older = '0;
      end else begin : g_mirror
         assign older = delay_ff[OLD_AGE-1];
      end

      if (k == CELL_COUNT - 1) begin : g_tail
         assign next_pair = '0;
      end else begin : g_link
         assign next_pair = pair[k+1];
      end

      sfir_pair_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .newer_sample (newer),
         .older_sample (older),
         .pair_next    (next_pair),
         .pair         (pair[k])
      );
   end

   sfir_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CELL_COUNT   (CELL_COUNT)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .pair   (pair[0]),
      .coef   (coef_at(8'(cnt_ff))),
      .result (mac_result)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FEED;
               cnt_in   = '0;
            end
         end
         ST_FEED: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // hold the result until the receiver takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_data_in  = mac_result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.sample_out = out_data_ff;

endmodule

>>> rtl/sfir_pair_cell.sv
// Pre-add cell: forms one mirrored pair sum and passes it down the chain.
module sfir_pair_cell #(
   parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  sfir_pkg::sfir_cell_ctrl_type     ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]   newer_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]   older_sample,
   input  logic signed [SAMPLE_WIDTH:0]     pair_next,
   output logic signed [SAMPLE_WIDTH:0]     pair
);
   import sfir_pkg::*;

   logic signed [SAMPLE_WIDTH:0] pair_ff;
   logic signed [SAMPLE_WIDTH:0] pair_in;

   always_comb begin
      pair_in = pair_ff;
      if (ctrl.load) begin
         pair_in = (SAMPLE_WIDTH+1)'(newer_sample) + (SAMPLE_WIDTH+1)'(older_sample);
      end else if (ctrl.shift) begin
         pair_in = pair_next;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair = pair_ff;

endmodule

>>> rtl/sfir_mac.sv
// Shared multiply-accumulate at the head of the chain, with round and saturate.
module sfir_mac #(
   parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH_DEF,
   parameter int CELL_COUNT   = (sfir_pkg::TAP_COUNT_DEF + 1) / 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sfir_pkg::sfir_mac_ctrl_type          ctrl,
   input  logic signed [SAMPLE_WIDTH:0]         pair,
   input  logic signed [sfir_pkg::COEF_W-1:0]   coef,
   output logic signed [SAMPLE_WIDTH-1:0]       result
);
   import sfir_pkg::*;

   localparam int PAIR_W = SAMPLE_WIDTH + 1;
   localparam int PROD_W = PAIR_W + COEF_W;
   localparam int ACC_W  = SAMPLE_WIDTH + COEF_W + $clog2(CELL_COUNT) + 2;

   localparam logic signed [ACC_W:0] HALF    = (ACC_W+1)'(2 ** (COEF_FRAC - 1));
   localparam logic signed [ACC_W:0] SAT_MAX =
      {{(ACC_W - SAMPLE_WIDTH + 2){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W:0] SAT_MIN = ~SAT_MAX;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic                     prod_vld_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W:0]    biased;
   logic signed [ACC_W:0]    shifted;

   always_comb begin
      prod_in     = pair * coef;
      prod_vld_in = ctrl.feed;
      acc_in      = acc_ff;
      if (ctrl.clear) begin
         prod_vld_in = 1'b0;
         acc_in      = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      biased  = (ACC_W+1)'(acc_ff) + HALF;
      shifted = biased >>> COEF_FRAC;
      if (shifted > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         result = shifted[SAMPLE_WIDTH-1:0];
      end
   end

endmodule
